// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assert fail");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error("never fail");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ===== rtl/core/nmsp_pkg.sv =====
`default_nettype none
package nmsp_pkg;
  localparam int NodeCap    = 32;
  localparam int EdgeCap    = 256;
  localparam int WeightBits = 16;
  localparam int NodeW      = $clog2(NodeCap);
  localparam int EdgeW      = $clog2(EdgeCap);
  localparam int DistW      = 24;
  localparam int StackDepth = 32;
  localparam logic [DistW-1:0] DistMax = '1;

  typedef enum logic [1:0] {
    FN_ADD_NODE = 2'd0, FN_ADD_EDGE = 2'd1, FN_QUERY = 2'd2, FN_NONE = 2'd3
  } func_e;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NODE_FULL = 3'd1;
  localparam logic [2:0] ST_BAD_NODE  = 3'd2;
  localparam logic [2:0] ST_EDGE_FULL = 3'd3;
  localparam logic [2:0] ST_NONE      = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] src_node;
    logic [4:0] dest_node;
    logic [15:0] edge_weight;
    logic       airport_flag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  node_id;
    logic [23:0] path_distance;
    logic        last_flag;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic latch_in;     // capture input item
    logic add_node;
    logic add_edge;
    logic init_clr;     // clear search arrays, seed start
    logic sel_clr;      // restart selection scan
    logic sel_step;     // examine node at scan index
    logic settle;       // settle selected node, load edge index
    logic rel_step;     // examine one edge (read data valid)
    logic rel_next;     // advance edge read address
    logic tgt_clr;
    logic tgt_step;
    logic walk_start;
    logic walk_step;
    logic emit_load;    // load output register
    logic emit_path;    // path result (else status result)
    logic [2:0] emit_status;
    logic emit_pop;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic node_full;
    logic edge_full;
    logic edge_bad;
    logic src_bad;
    logic scan_done;    // selection scan index past last node
    logic sel_found;
    logic rel_done;     // edge index at zero
    logic tgt_done;
    logic tgt_found;
    logic walk_done;
    logic pop_last;
    logic out_busy;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/nmsp_if.sv =====
`default_nettype none
interface nmsp_in_if;
  logic valid;
  logic ready;
  nmsp_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nmsp_out_if;
  logic valid;
  logic ready;
  nmsp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nmsp_datapath.sv =====
`default_nettype none
module nmsp_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire nmsp_pkg::in_item_t in_data_i,
  input  wire nmsp_pkg::dp_cmd_t  cmd_i,
  output nmsp_pkg::dp_stat_t      stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output nmsp_pkg::out_item_t     out_data_o
);
  import nmsp_pkg::*;

  // item registers
  in_item_t         item_q;
  logic [NodeW:0]   node_total_q;
  logic [EdgeW:0]   edge_total_q;
  logic [NodeCap-1:0] marked_q, visited_q, reached_q;

  // edge memory: from, to, weight
  localparam int EW = 2*NodeW + WeightBits;
  logic [EW-1:0] edge_mem [EdgeCap];
  logic [EW-1:0] edge_rd_q;
  logic [EdgeW:0] eidx_q;

  // per node tables and the path stack (flops, read at several indices)
  logic [DistW-1:0] dist_q [NodeCap];
  logic [NodeW-1:0] par_q [NodeCap];
  logic [NodeW-1:0] stack_q [StackDepth];

  logic [NodeW:0]   scan_q;
  logic [NodeW-1:0] best_q;
  logic             best_ok_q;
  logic [NodeW-1:0] u_q;
  logic [DistW-1:0] du_q, total_q;
  logic [NodeW-1:0] cur_q;
  logic [5:0]       depth_q;
  logic             walk_end_q;
  out_item_t        out_q;

  logic [NodeW-1:0] sidx, ef, et;
  logic [WeightBits-1:0] ew;
  logic [DistW:0]   nd_w;
  logic [DistW-1:0] nd;
  logic             cand;
  logic             et_ok;

  assign sidx = scan_q[NodeW-1:0];
  assign ef = edge_rd_q[EW-1 -: NodeW];
  assign et = edge_rd_q[WeightBits +: NodeW];
  assign ew = edge_rd_q[WeightBits-1:0];
  assign nd_w = {1'b0, du_q} + (DistW+1)'(ew);
  assign nd = nd_w[DistW] ? DistMax : nd_w[DistW-1:0];
  assign et_ok = {1'b0, et} < node_total_q;

  // candidate for selection / target scan
  always_comb begin
    cand = 1'b0;
    if (cmd_i.sel_step)
      cand = !visited_q[sidx] && reached_q[sidx] &&
             (!best_ok_q || dist_q[sidx] < dist_q[best_q]);
    else if (cmd_i.tgt_step)
      cand = marked_q[sidx] && (sidx != item_q.src_node) && reached_q[sidx] &&
             (!best_ok_q || dist_q[sidx] < dist_q[best_q]);
  end

  // edge memory port
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_edge)
      edge_mem[edge_total_q[EdgeW-1:0]] <= {item_q.src_node, item_q.dest_node,
                                             item_q.edge_weight[WeightBits-1:0]};
    edge_rd_q <= edge_mem[eidx_q[EdgeW-1:0] - 1'b1];
  end

  // tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.rel_step && eidx_q != '0 && ef == u_q && et_ok &&
        !visited_q[et] && (!reached_q[et] || nd < dist_q[et])) begin
      dist_q[et] <= nd;
      par_q[et]  <= u_q;
    end
    if (cmd_i.init_clr) dist_q[item_q.src_node] <= '0;
    if (cmd_i.walk_step && !walk_end_q) stack_q[depth_q[4:0]] <= cur_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_total_q <= '0; edge_total_q <= '0; marked_q <= '0;
      visited_q <= '0; reached_q <= '0; out_q <= '0; out_valid_o <= 1'b0;
      item_q <= '0; scan_q <= '0; best_q <= '0; best_ok_q <= 1'b0; u_q <= '0;
      du_q <= '0; total_q <= '0; cur_q <= '0; depth_q <= '0; eidx_q <= '0;
      walk_end_q <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && !cmd_i.emit_load) out_valid_o <= 1'b0;
      if (cmd_i.latch_in) item_q <= in_data_i;
      if (cmd_i.add_node) begin
        marked_q[node_total_q[NodeW-1:0]] <= item_q.airport_flag;
        node_total_q <= node_total_q + 1'b1;
      end
      if (cmd_i.add_edge) edge_total_q <= edge_total_q + 1'b1;
      // start node is the only reached one
      if (cmd_i.init_clr) begin
        visited_q <= '0;
        reached_q <= NodeCap'(1) << item_q.src_node;
      end
      if (cmd_i.sel_clr || cmd_i.tgt_clr) begin
        scan_q <= '0; best_ok_q <= 1'b0;
      end
      if (cmd_i.sel_step || cmd_i.tgt_step) begin
        if (cand) begin best_q <= sidx; best_ok_q <= 1'b1; end
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.settle) begin
        visited_q[best_q] <= 1'b1;
        u_q <= best_q; du_q <= dist_q[best_q];
        eidx_q <= edge_total_q;
      end
      if (cmd_i.rel_step && eidx_q != '0 && ef == u_q && et_ok && !visited_q[et] &&
          (!reached_q[et] || nd < dist_q[et]))
        reached_q[et] <= 1'b1;
      if (cmd_i.rel_next) eidx_q <= eidx_q - 1'b1;
      if (cmd_i.walk_start) begin
        cur_q <= best_q; total_q <= dist_q[best_q]; depth_q <= '0;
        walk_end_q <= 1'b0;
      end
      if (cmd_i.walk_step && !walk_end_q) begin
        depth_q <= depth_q + 1'b1;
        if (cur_q == item_q.src_node || depth_q == 6'(StackDepth-1)) walk_end_q <= 1'b1;
        cur_q <= par_q[cur_q];
      end
      if (cmd_i.emit_load) begin
        out_valid_o <= 1'b1;
        if (cmd_i.emit_path) begin
          out_q.status <= ST_OK;
          out_q.node_id <= stack_q[5'(depth_q - 1'b1)];
          out_q.path_distance <= total_q;
          out_q.last_flag <= (depth_q == 6'd1);
        end else begin
          out_q.status <= cmd_i.emit_status;
          out_q.node_id <= (cmd_i.emit_status == ST_OK && item_q.func == FN_ADD_NODE)
                           ? node_total_q[NodeW-1:0] : '0;
          out_q.path_distance <= '0;
          out_q.last_flag <= 1'b1;
        end
      end
      if (cmd_i.emit_pop) depth_q <= depth_q - 1'b1;
    end
  end

  assign out_data_o = out_q;

  // status toward the controller
  always_comb begin
    stat_o.func      = item_q.func;
    stat_o.node_full = node_total_q >= (NodeW+1)'(NodeCap);
    stat_o.edge_full = edge_total_q >= (EdgeW+1)'(EdgeCap);
    stat_o.edge_bad  = ({1'b0, item_q.src_node} >= node_total_q) ||
                       ({1'b0, item_q.dest_node} >= node_total_q);
    stat_o.src_bad   = {1'b0, item_q.src_node} >= node_total_q;
    stat_o.scan_done = scan_q >= node_total_q;
    stat_o.sel_found = best_ok_q;
    stat_o.rel_done  = eidx_q == '0;
    stat_o.tgt_done  = scan_q >= node_total_q;
    stat_o.tgt_found = best_ok_q;
    stat_o.walk_done = walk_end_q;
    stat_o.pop_last  = depth_q == 6'd1;
    stat_o.out_busy  = out_valid_o && !out_ready_i;
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_node_ovf, clk_i, rst_ni, node_total_q > (NodeW+1)'(NodeCap))
  `ASSERT_NEVER(a_edge_ovf, clk_i, rst_ni, edge_total_q > (EdgeW+1)'(EdgeCap))
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_q)))
endmodule
`default_nettype wire

// ===== rtl/core/nmsp_ctrl.sv =====
`default_nettype none
module nmsp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire nmsp_pkg::dp_stat_t stat_i,
  output nmsp_pkg::dp_cmd_t       cmd_o
);
  import nmsp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SEL, S_SETTLE, S_RD, S_REL, S_TGT, S_WALK, S_EMIT,
    S_RESULT, S_WAITOUT
  } state_e;

  state_e state_q, state_d;
  logic [2:0] res_q, res_d;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    res_d = res_q;
    in_ready_o = (state_q == S_IDLE);
    cmd_o.latch_in = in_valid_i && in_ready_o;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (func_e'(stat_i.func))
          FN_ADD_NODE: begin
            res_d = stat_i.node_full ? ST_NODE_FULL : ST_OK;
            state_d = S_RESULT;
          end
          FN_ADD_EDGE: begin
            res_d = stat_i.edge_bad ? ST_BAD_NODE :
                    stat_i.edge_full ? ST_EDGE_FULL : ST_OK;
            state_d = S_RESULT;
          end
          FN_QUERY: begin
            if (stat_i.src_bad) begin
              res_d = ST_BAD_NODE; state_d = S_RESULT;
            end else begin
              cmd_o.init_clr = 1'b1; cmd_o.sel_clr = 1'b1; state_d = S_SEL;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      // scan for the nearest unsettled reached node
      S_SEL: begin
        if (!stat_i.scan_done) cmd_o.sel_step = 1'b1;
        else if (stat_i.sel_found) begin
          cmd_o.settle = 1'b1; state_d = S_SETTLE;
        end else begin
          cmd_o.tgt_clr = 1'b1; state_d = S_TGT;
        end
      end
      S_SETTLE: state_d = S_RD;
      // the edge read completes in S_RD, S_REL examines the edge
      S_RD: begin
        if (stat_i.rel_done) begin
          cmd_o.sel_clr = 1'b1; state_d = S_SEL;
        end else state_d = S_REL;
      end
      S_REL: begin
        cmd_o.rel_step = 1'b1; cmd_o.rel_next = 1'b1; state_d = S_RD;
      end
      S_TGT: begin
        if (!stat_i.tgt_done) cmd_o.tgt_step = 1'b1;
        else if (stat_i.tgt_found) begin
          cmd_o.walk_start = 1'b1; state_d = S_WALK;
        end else begin
          res_d = ST_NONE; state_d = S_RESULT;
        end
      end
      S_WALK: begin
        if (!stat_i.walk_done) cmd_o.walk_step = 1'b1;
        else state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit_load = 1'b1; cmd_o.emit_path = 1'b1; cmd_o.emit_pop = 1'b1;
          if (stat_i.pop_last) state_d = S_IDLE;
        end
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit_load = 1'b1; cmd_o.emit_status = res_q;
          cmd_o.add_node = (func_e'(stat_i.func) == FN_ADD_NODE) && res_q == ST_OK;
          cmd_o.add_edge = (func_e'(stat_i.func) == FN_ADD_EDGE) && res_q == ST_OK;
          state_d = S_WAITOUT;
        end
      end
      S_WAITOUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q <= ST_OK;
    end else begin
      state_q <= state_d;
      res_q <= res_d;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o |-> (state_q == S_IDLE))
  `ASSERT_NEVER(a_one_scan, clk_i, rst_ni, cmd_o.sel_step && cmd_o.tgt_step)
  `ASSERT_IMPL(a_settle_rd, clk_i, rst_ni, cmd_o.settle |=> (state_q == S_SETTLE))
endmodule
`default_nettype wire

// ===== rtl/core/nearest_marked_node_shortest_path_top.sv =====
`default_nettype none
// Nearest marked node search engine.
// in_if carries one command item: func 0 adds a node (marked by
// airport_flag), func 1 adds a directed edge, func 2 queries from src_node.
// func 3 is dropped with no result.
// out_if carries results: add node and add edge give one result each; a
// query gives the path from start to the nearest marked node, one node per
// result, last_flag set on the final one, or a single error status.
// An add result is loaded once the item is decoded and the output is free,
// and the next item is taken only after that result is loaded. A query
// repeats, for each settled node, a selection scan over all nodes and a
// scan of the whole edge memory (a read step and an examine step per edge);
// these scans set how long a query runs.
// One item is processed at a time; in_if.ready is high only when idle.
// Reset clears the node and edge counts and marked flags; no clearing pass.
// When the receiver stalls, the output register holds its item and the
// engine waits before emitting the next result.
module nearest_marked_node_shortest_path_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nmsp_in_if.sink    in_if,
  nmsp_out_if.source out_if
);
  import nmsp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nmsp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nmsp_datapath u_dp (
    .clk_i, .rst_ni,
    .in_data_i   (in_if.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );
endmodule
`default_nettype wire

// ===== verif/tb_nearest_marked_node_shortest_path_top.sv =====
module tb_nearest_marked_node_shortest_path_top;
  import nmsp_pkg::*;

  logic clk_i;
  logic rst_ni;

  nmsp_in_if  cmd_if ();
  nmsp_out_if res_if ();

  nearest_marked_node_shortest_path_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (cmd_if.sink),
    .out_if(res_if.source)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // graph shadow
  int unsigned        g_nodes;
  bit                 g_marked [NodeCap];
  int unsigned        g_edges;
  int unsigned        g_efrom  [EdgeCap];
  int unsigned        g_eto    [EdgeCap];
  int unsigned        g_ecost  [EdgeCap];

  out_item_t          expected_results [$];
  int                 mismatches;
  int                 results_seen;
  int                 paths_seen;
  int                 idle_cycles;
  bit                 quiet_phase;

  // one directed-stimulus row; the predictor's result is checked against the typed one when check_row is set
  typedef struct {
    in_item_t  item;
    bit        check_row;
    out_item_t want;
  } stim_row_t;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic out_item_t mk_res(logic [2:0] st, logic [4:0] id,
                                       logic [23:0] d, logic lst);
    out_item_t r;
    r.status = st;
    r.node_id = id;
    r.path_distance = d;
    r.last_flag = lst;
    return r;
  endfunction

  // Array-scan shortest path search, pushes the expected path results or an ST_NONE result
  task automatic predict_nearest_path(input int unsigned start);
    int unsigned dist_v [NodeCap];
    int unsigned par  [NodeCap];
    bit          seen [NodeCap];
    bit          done [NodeCap];
    int          u;
    int          tgt;
    int unsigned nd;
    int unsigned v;
    int unsigned cur;
    int unsigned walk [$];
    for (int i = 0; i < NodeCap; i++) begin
      dist_v[i] = 0; par[i] = 0; seen[i] = 0; done[i] = 0;
    end
    seen[start] = 1;
    for (int r = 0; r < g_nodes; r++) begin
      u = -1;
      for (int j = 0; j < g_nodes; j++)
        if (!done[j] && seen[j] && (u < 0 || dist_v[j] < dist_v[u])) u = j;
      if (u < 0) break;
      done[u] = 1;
      for (int e = g_edges - 1; e >= 0; e--) begin
        if (g_efrom[e] != u) continue;
        v = g_eto[e];
        if (v >= g_nodes || done[v]) continue;
        nd = dist_v[u] + g_ecost[e];
        if (nd > DistMax) nd = DistMax;
        if (!seen[v] || nd < dist_v[v]) begin
          dist_v[v] = nd; par[v] = u; seen[v] = 1;
        end
      end
    end
    tgt = -1;
    for (int i = 0; i < g_nodes; i++)
      if (g_marked[i] && i != start && seen[i] && (tgt < 0 || dist_v[i] < dist_v[tgt]))
        tgt = i;
    if (tgt < 0) begin
      expected_results.push_back(mk_res(ST_NONE, '0, '0, 1'b1));
      return;
    end
    // walk back from the target, keeping at most StackDepth nodes
    cur = tgt;
    while (walk.size() < StackDepth) begin
      walk.push_front(cur);
      if (cur == start) break;
      cur = par[cur];
    end
    foreach (walk[k])
      expected_results.push_back(mk_res(ST_OK, walk[k][4:0], dist_v[tgt][23:0],
                                        k == walk.size() - 1));
  endtask

  // expected results of one accepted item
  task automatic predict_item(input in_item_t it);
    case (func_e'(it.func))
      FN_ADD_NODE: begin
        if (g_nodes >= NodeCap) begin
          expected_results.push_back(mk_res(ST_NODE_FULL, '0, '0, 1'b1));
        end else begin
          g_marked[g_nodes] = it.airport_flag;
          expected_results.push_back(mk_res(ST_OK, g_nodes[4:0], '0, 1'b1));
          g_nodes++;
        end
      end
      FN_ADD_EDGE: begin
        if (it.src_node >= g_nodes || it.dest_node >= g_nodes) begin
          expected_results.push_back(mk_res(ST_BAD_NODE, '0, '0, 1'b1));
        end else if (g_edges >= EdgeCap) begin
          expected_results.push_back(mk_res(ST_EDGE_FULL, '0, '0, 1'b1));
        end else begin
          g_efrom[g_edges] = it.src_node;
          g_eto[g_edges] = it.dest_node;
          g_ecost[g_edges] = it.edge_weight;
          g_edges++;
          expected_results.push_back(mk_res(ST_OK, '0, '0, 1'b1));
        end
      end
      FN_QUERY: begin
        if (it.src_node >= g_nodes)
          expected_results.push_back(mk_res(ST_BAD_NODE, '0, '0, 1'b1));
        else
          predict_nearest_path(it.src_node);
      end
      default: ;
    endcase
  endtask

  // send one item with random leading gaps; valid stays up until the next gap
  task automatic send_item(input in_item_t it);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    do @(posedge clk_i); while (!cmd_if.ready);
    predict_item(it);
  endtask

  function automatic in_item_t mk_cmd(func_e f, logic [4:0] s, logic [4:0] d,
                                      logic [15:0] w, logic fl);
    in_item_t it;
    it.func = f;
    it.src_node = s;
    it.dest_node = d;
    it.edge_weight = w;
    it.airport_flag = fl;
    return it;
  endfunction

  function automatic in_item_t random_cmd();
    logic [15:0] w;
    logic [4:0]  s;
    logic [4:0]  d;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: w = 16'hFFFF;
      1: w = 16'($urandom_range(0, 3));
      default: w = 16'($urandom);
    endcase
    s = 5'($urandom);
    d = 5'($urandom);
    if (pick < 2)
      return mk_cmd(FN_NONE, s, d, 16'($urandom), 1'($urandom));
    if (pick < 25)
      return mk_cmd(FN_ADD_NODE, s, d, 16'($urandom), 1'($urandom));
    if (pick < 70) begin
      if (g_nodes > 0 && pick > 30) begin
        s = 5'($urandom_range(0, g_nodes - 1));
        d = 5'($urandom_range(0, g_nodes - 1));
      end
      return mk_cmd(FN_ADD_EDGE, s, d, w, 1'($urandom));
    end
    if (g_nodes > 0 && pick > 72) s = 5'($urandom_range(0, g_nodes - 1));
    return mk_cmd(FN_QUERY, s, d, 16'($urandom), 1'($urandom));
  endfunction

  // result side: random stalls, in-order field compare
  initial begin
    out_item_t want;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", res_if.data));
        end else begin
          want = expected_results.pop_front();
          if (res_if.data.status !== want.status)
            report_mismatch($sformatf("status %0d want %0d", res_if.data.status, want.status));
          if (res_if.data.node_id !== want.node_id)
            report_mismatch($sformatf("node_id %0d want %0d", res_if.data.node_id, want.node_id));
          if (res_if.data.path_distance !== want.path_distance)
            report_mismatch($sformatf("distance %0d want %0d",
                                      res_if.data.path_distance, want.path_distance));
          if (res_if.data.last_flag !== want.last_flag)
            report_mismatch($sformatf("last_flag %0b want %0b",
                                      res_if.data.last_flag, want.last_flag));
          if (want.status == ST_OK && want.path_distance != 0 && want.last_flag) paths_seen++;
        end
      end
      if (!quiet_phase && res_if.ready && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 400000) begin
        $display("timeout: no handshake for %0d cycles", idle_cycles);
        $display("tb_nearest_marked_node_shortest_path_top: errors");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    stim_row_t rows [$];
    int        settle_cnt;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    rst_ni = 1'b0;
    mismatches = 0;
    results_seen = 0;
    paths_seen = 0;
    quiet_phase = 0;
    g_nodes = 0;
    g_edges = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: empty graph errors, small graph, ties, noise
    rows.push_back('{mk_cmd(FN_QUERY, 5'd0, 5'd0, 16'd0, 1'b0), 1,
                     mk_res(ST_BAD_NODE, '0, '0, 1'b1)});
    rows.push_back('{mk_cmd(FN_ADD_EDGE, 5'd0, 5'd0, 16'd1, 1'b0), 1,
                     mk_res(ST_BAD_NODE, '0, '0, 1'b1)});
    rows.push_back('{mk_cmd(FN_ADD_NODE, 5'd31, 5'd31, 16'hFFFF, 1'b0), 1,
                     mk_res(ST_OK, 5'd0, '0, 1'b1)});
    rows.push_back('{mk_cmd(FN_QUERY, 5'd0, 5'd0, 16'd0, 1'b0), 1,
                     mk_res(ST_NONE, '0, '0, 1'b1)});
    rows.push_back('{mk_cmd(FN_ADD_NODE, 5'd0, 5'd0, 16'd0, 1'b1), 1,
                     mk_res(ST_OK, 5'd1, '0, 1'b1)});
    rows.push_back('{mk_cmd(FN_ADD_NODE, 5'd0, 5'd0, 16'd0, 1'b1), 1,
                     mk_res(ST_OK, 5'd2, '0, 1'b1)});
    rows.push_back('{mk_cmd(FN_ADD_NODE, 5'd0, 5'd0, 16'd0, 1'b0), 0, '0});
    rows.push_back('{mk_cmd(FN_ADD_EDGE, 5'd0, 5'd31, 16'd1, 1'b0), 1,
                     mk_res(ST_BAD_NODE, '0, '0, 1'b1)});
    rows.push_back('{mk_cmd(FN_ADD_EDGE, 5'd0, 5'd3, 16'hFFFF, 1'b1), 0, '0});
    rows.push_back('{mk_cmd(FN_ADD_EDGE, 5'd3, 5'd1, 16'hFFFF, 1'b0), 0, '0});
    rows.push_back('{mk_cmd(FN_ADD_EDGE, 5'd0, 5'd2, 16'd5, 1'b0), 0, '0});
    rows.push_back('{mk_cmd(FN_ADD_EDGE, 5'd0, 5'd1, 16'd5, 1'b0), 0, '0});
    rows.push_back('{mk_cmd(FN_QUERY, 5'd0, 5'd0, 16'd0, 1'b0), 0, '0});
    rows.push_back('{mk_cmd(FN_NONE, 5'd31, 5'd31, 16'hFFFF, 1'b1), 0, '0});
    rows.push_back('{mk_cmd(FN_ADD_EDGE, 5'd0, 5'd1, 16'd0, 1'b0), 0, '0});
    rows.push_back('{mk_cmd(FN_QUERY, 5'd3, 5'd0, 16'd0, 1'b0), 0, '0});
    rows.push_back('{mk_cmd(FN_QUERY, 5'd2, 5'd0, 16'd0, 1'b0), 1,
                     mk_res(ST_NONE, '0, '0, 1'b1)});
    rows.push_back('{mk_cmd(FN_QUERY, 5'd31, 5'd0, 16'd0, 1'b0), 1,
                     mk_res(ST_BAD_NODE, '0, '0, 1'b1)});
    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (rows[i].check_row && expected_results.size() > 0 &&
          expected_results[$] != rows[i].want)
        report_mismatch($sformatf("predictor row %0d disagrees with table", i));
    end

    // fill to 32 nodes and add a long edge chain: exercises a full node table and a search over the chain
    while (g_nodes < NodeCap)
      send_item(mk_cmd(FN_ADD_NODE, '0, '0, '0, g_nodes == NodeCap - 1));
    send_item(mk_cmd(FN_ADD_NODE, '0, '0, '0, 1'b1));
    for (int i = 3; i < NodeCap - 1; i++)
      send_item(mk_cmd(FN_ADD_EDGE, i[4:0], 5'(i + 1), 16'hFFFF, 1'b0));
    send_item(mk_cmd(FN_QUERY, 5'd0, '0, '0, 1'b0));

    // random part
    for (int n = 0; n < 30; n++) begin
      if (n == 24) quiet_phase = 1;
      send_item(random_cmd());
    end

    send_item(mk_cmd(FN_ADD_EDGE, 5'd0, 5'd1, 16'd1, 1'b0));
    send_item(mk_cmd(FN_QUERY, 5'($urandom_range(0, NodeCap - 1)), '0, '0, 1'b0));
    cmd_if.valid <= 1'b0;

    while (expected_results.size() > 0) @(posedge clk_i);
    settle_cnt = 0;
    while (settle_cnt < 200) begin
      @(posedge clk_i);
      settle_cnt++;
    end
    $display("covered %0d results, %0d nonzero paths, %0d nodes, %0d edges",
             results_seen, paths_seen, g_nodes, g_edges);
    if (mismatches == 0)
      $display("tb_nearest_marked_node_shortest_path_top: clean");
    else
      $display("tb_nearest_marked_node_shortest_path_top: errors");
    $finish;
  end

endmodule
